[design/sorted_list_engine_macros.svh]
// Assertion macros for the sorted list engine checker
`ifndef SORTED_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_ENGINE_MACROS_SVH

// checked only while out of reset
`define SLE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sorted_list_engine check failed");

// checked at every edge, reset included
`define SLE_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("sorted_list_engine check failed");

`endif

[design/sle_pkg.sv]
`default_nettype none
package sle_pkg;

	localparam int CAPACITY    = 32;
	localparam int MAX_RESULTS = 32;
	localparam int VAL_W       = 32;
	localparam int CMD_W       = 2;
	localparam int STAT_W      = 2;
	localparam int POS_W       = 5;
	localparam int CNT_OUT_W   = 6;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int DUMP_N      = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
	localparam int DIDX_W      = $clog2(DUMP_N);
	localparam int OUT_FLD_W   = VAL_W + POS_W + CNT_OUT_W;
	localparam int OUT_DATA_W  = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int PAD_W       = OUT_DATA_W - OUT_FLD_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_DUMP   = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY,
		ST_DUMP
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CMP,
		OP_INS,
		OP_DEL,
		OP_ROT
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] key;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		logic ring;
		logic tail;
	} cell_pos_t;

endpackage
`default_nettype wire

[design/sle_cell.sv]
`default_nettype none
module sle_cell (
	input  wire logic                             clk,
	input  wire sle_pkg::cell_ctrl_t              ctrl,
	input  wire sle_pkg::cell_pos_t               pos,
	input  wire logic signed [sle_pkg::VAL_W-1:0] left_val,
	input  wire logic signed [sle_pkg::VAL_W-1:0] right_val,
	input  wire logic signed [sle_pkg::VAL_W-1:0] head_val,
	input  wire logic                             left_ge,
	output logic signed [sle_pkg::VAL_W-1:0]      val,
	output logic                                  ge,
	output logic                                  eq
);

	logic signed [sle_pkg::VAL_W-1:0] val_q;
	logic                             ge_q;
	logic                             eq_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			sle_pkg::OP_CMP: begin
				ge_q <= !(pos.valid && (val_q < ctrl.key));
				eq_q <= pos.valid && (val_q == ctrl.key);
			end
			sle_pkg::OP_INS: begin
				if (left_ge) begin
					val_q <= left_val;
				end else if (ge_q) begin
					val_q <= ctrl.key;
				end
			end
			sle_pkg::OP_DEL: begin
				if (ge_q) begin
					val_q <= right_val;
				end
			end
			sle_pkg::OP_ROT: begin
				if (pos.ring) begin
					val_q <= pos.tail ? head_val : right_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign ge  = ge_q;
	assign eq  = eq_q;

endmodule
`default_nettype wire

[design/sorted_list_engine.sv]
// channel   dir  tdata                                      tuser        tlast
// s_axis    in   [31:0] value                               [1:0] command  -
// m_axis    out  [31:0] entry_value, [36:32] position,      [1:0] status   last
//                [42:37] entry_count, [47:43] zero
// Insert and delete run accept, a compare in every cell, then the shift.
// A dump gives one entry a cycle from the head cell while the list rotates,
// unless the output stalls. The compare flags and the shift sit in the row
// of cells; a full row costs nothing extra. Reset empties the list at once,
// no clearing pass. A stalled output holds its transaction; a new input is
// taken while a finished one still waits.
`default_nettype none
module sorted_list_engine (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic signed [sle_pkg::VAL_W-1:0]      s_axis_tdata,  // value
	input  wire logic [sle_pkg::CMD_W-1:0]             s_axis_tuser,  // command
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// entry_value, position, entry_count, zero pad
	output logic [sle_pkg::OUT_DATA_W-1:0]             m_axis_tdata,
	output logic [sle_pkg::STAT_W-1:0]                 m_axis_tuser,  // status
	output logic                                       m_axis_tlast
);

	localparam int CAP = sle_pkg::CAPACITY;

	sle_pkg::state_t                  state_q, state_d;
	logic [sle_pkg::CNT_W-1:0]        count_q, count_d;
	logic [sle_pkg::DIDX_W-1:0]       dump_idx_q;
	logic [sle_pkg::CMD_W-1:0]        cmd_q;
	logic signed [sle_pkg::VAL_W-1:0] key_q;

	logic                             out_valid_q;
	sle_pkg::status_t                 out_status_q;
	logic signed [sle_pkg::VAL_W-1:0] out_val_q;
	logic [sle_pkg::POS_W-1:0]        out_pos_q;
	logic [sle_pkg::CNT_OUT_W-1:0]    out_cnt_q;
	logic                             out_last_q;

	sle_pkg::op_t                     op;
	logic                             out_load;
	logic                             out_free;
	logic                             in_acc;
	sle_pkg::status_t                 res_status;
	logic signed [sle_pkg::VAL_W-1:0] res_val;
	logic [sle_pkg::POS_W-1:0]        res_pos;
	logic [sle_pkg::CNT_W-1:0]        res_cnt;
	logic                             res_last;

	sle_pkg::cell_ctrl_t              ctrl;
	logic signed [sle_pkg::VAL_W-1:0] cell_val [CAP];
	logic [CAP-1:0]                   cell_ge;
	logic [CAP-1:0]                   cell_eq;
	logic [CAP-1:0]                   first_ge;
	logic                             found;
	logic [sle_pkg::IDX_W-1:0]        hit_idx;
	logic [sle_pkg::CNT_W-1:0]        n_dump;
	logic                             dump_last;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign n_dump   = (count_q > sle_pkg::CNT_W'(sle_pkg::DUMP_N)) ?
		sle_pkg::CNT_W'(sle_pkg::DUMP_N) : count_q;
	assign dump_last = (sle_pkg::CNT_W'(dump_idx_q) == (n_dump - sle_pkg::CNT_W'(1)));

	assign ctrl.op  = op;
	assign ctrl.key = key_q;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		sle_pkg::cell_pos_t               pos;
		logic signed [sle_pkg::VAL_W-1:0] left_val;
		logic signed [sle_pkg::VAL_W-1:0] right_val;
		logic                             left_ge;

		assign pos.valid = sle_pkg::CNT_W'(i) < count_q;
		assign pos.ring  = sle_pkg::CNT_W'(i) < n_dump;
		assign pos.tail  = sle_pkg::CNT_W'(i) == (n_dump - sle_pkg::CNT_W'(1));

		if (i == 0) begin : g_head
			assign left_val    = cell_val[0];
			assign left_ge     = 1'b0;
			assign first_ge[i] = cell_ge[i];
		end else begin : g_body
			assign left_val    = cell_val[i-1];
			assign left_ge     = cell_ge[i-1];
			assign first_ge[i] = cell_ge[i] && !cell_ge[i-1];
		end

		if (i == CAP - 1) begin : g_tail
			assign right_val = cell_val[i];
		end else begin : g_mid
			assign right_val = cell_val[i+1];
		end

		sle_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.pos       (pos),
			.left_val  (left_val),
			.right_val (right_val),
			.head_val  (cell_val[0]),
			.left_ge   (left_ge),
			.val       (cell_val[i]),
			.ge        (cell_ge[i]),
			.eq        (cell_eq[i])
		);
	end

	assign found = |(first_ge & cell_eq);

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAP; i++) begin
			if (first_ge[i]) begin
				hit_idx = hit_idx | sle_pkg::IDX_W'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sle_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (s_axis_tuser)
						sle_pkg::CMD_INSERT,
						sle_pkg::CMD_DELETE: state_d = sle_pkg::ST_CMP;
						sle_pkg::CMD_DUMP: begin
							state_d = (count_q == '0) ? sle_pkg::ST_APPLY : sle_pkg::ST_DUMP;
						end
						default: state_d = sle_pkg::ST_IDLE;
					endcase
				end
			end
			sle_pkg::ST_CMP: state_d = sle_pkg::ST_APPLY;
			sle_pkg::ST_APPLY: begin
				if (out_free) begin
					state_d = sle_pkg::ST_IDLE;
				end
			end
			sle_pkg::ST_DUMP: begin
				if (out_free && dump_last) begin
					state_d = sle_pkg::ST_IDLE;
				end
			end
			default: state_d = sle_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		op            = sle_pkg::OP_HOLD;
		out_load      = 1'b0;
		count_d       = count_q;
		res_status    = sle_pkg::STAT_OK;
		res_val       = key_q;
		res_pos       = '0;
		res_cnt       = count_q;
		res_last      = 1'b1;
		case (state_q)
			sle_pkg::ST_IDLE: s_axis_tready = 1'b1;
			sle_pkg::ST_CMP:  op = sle_pkg::OP_CMP;
			sle_pkg::ST_APPLY: begin
				out_load = out_free;
				case (cmd_q)
					sle_pkg::CMD_INSERT: begin
						if (count_q >= sle_pkg::CNT_W'(CAP)) begin
							res_status = sle_pkg::STAT_FULL;
						end else begin
							res_pos = sle_pkg::POS_W'(hit_idx);
							count_d = count_q + sle_pkg::CNT_W'(1);
							op      = sle_pkg::OP_INS;
						end
					end
					sle_pkg::CMD_DELETE: begin
						if (count_q == '0) begin
							res_status = sle_pkg::STAT_EMPTY;
						end else if (!found) begin
							res_status = sle_pkg::STAT_NOT_FOUND;
						end else begin
							res_pos = sle_pkg::POS_W'(hit_idx);
							count_d = count_q - sle_pkg::CNT_W'(1);
							op      = sle_pkg::OP_DEL;
						end
					end
					default: begin
						res_status = sle_pkg::STAT_EMPTY;
						res_val    = '0;
					end
				endcase
				if (!out_free) begin
					op      = sle_pkg::OP_HOLD;
					count_d = count_q;
				end
				res_cnt = count_d;
			end
			sle_pkg::ST_DUMP: begin
				out_load = out_free;
				res_val  = cell_val[0];
				res_pos  = sle_pkg::POS_W'(dump_idx_q);
				res_last = dump_last;
				if (out_free) begin
					op = sle_pkg::OP_ROT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sle_pkg::ST_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (in_acc) begin
				dump_idx_q <= '0;
			end else if (op == sle_pkg::OP_ROT) begin
				dump_idx_q <= dump_idx_q + sle_pkg::DIDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= s_axis_tuser;
			key_q <= s_axis_tdata;
		end
		if (out_load) begin
			out_status_q <= res_status;
			out_val_q    <= res_val;
			out_pos_q    <= res_pos;
			out_cnt_q    <= sle_pkg::CNT_OUT_W'(res_cnt);
			out_last_q   <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{sle_pkg::PAD_W{1'b0}}, out_cnt_q, out_pos_q, out_val_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

[design/sle_checker.sv]
`default_nettype none
`include "sorted_list_engine_macros.svh"
module sle_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tready,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [sle_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input wire logic [sle_pkg::STAT_W-1:0]        m_axis_tuser,
	input wire logic                              m_axis_tlast
);

	localparam int CNT_LO = sle_pkg::VAL_W + sle_pkg::POS_W;
	localparam int CNT_HI = CNT_LO + sle_pkg::CNT_OUT_W - 1;

	logic [sle_pkg::CNT_OUT_W-1:0] out_cnt;
	logic                          out_full;

	assign out_cnt  = m_axis_tdata[CNT_HI:CNT_LO];
	assign out_full = m_axis_tvalid && (m_axis_tuser == sle_pkg::STAT_FULL);

	// no result out of reset
	`SLE_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !m_axis_tvalid)
	// a stalled transaction stays offered
	`SLE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	// refusal only when the store is full
	`SLE_ASSERT(a_full_cnt, out_full |-> out_cnt == sle_pkg::CNT_OUT_W'(sle_pkg::CAPACITY))
	// mid-dump: input held off, next entry follows straight away
	`SLE_ASSERT(a_dump_busy, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
	`SLE_ASSERT(a_dump_next, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);
`default_nettype wire

[bench/tb_sorted_list_engine.sv]
`timescale 1ns / 100ps
module tb_sorted_list_engine;
	import sle_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_AT      = 50;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int ITEM_TARGET  = 135;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] val;
		int                      gap;
		bit                      drain;
	} list_cmd_t;

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        pos;
		logic [CNT_OUT_W-1:0]    count;
		logic                    last;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic signed [VAL_W-1:0] s_axis_tdata = '0;  // value
	logic [CMD_W-1:0] s_axis_tuser = '0;         // command
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // entry_value, position, entry_count, pad
	logic [STAT_W-1:0] m_axis_tuser;             // status
	logic m_axis_tlast;

	sorted_list_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial forever #5 clk = ~clk;

	list_cmd_t   cmd_queue[$];
	list_reply_t list_replies[$];
	logic signed [VAL_W-1:0] shadow_list [CAPACITY];
	int shadow_len = 0;
	int faults = 0;

	// generator side bookkeeping
	logic signed [VAL_W-1:0] gen_pool[$];
	bit gen_quiet;
	bit drain_next;

	// ---------------------------------------------------------------- prediction

	function automatic void queue_reply(status_t st, logic signed [VAL_W-1:0] v, int p,
			bit last);
		list_reply_t r;
		r.status = st;
		r.value  = v;
		r.pos    = p[POS_W-1:0];
		r.count  = shadow_len[CNT_OUT_W-1:0];
		r.last   = last;
		list_replies.push_back(r);
	endfunction

	function automatic void update_sorted_list(logic [CMD_W-1:0] cmd,
			logic signed [VAL_W-1:0] val);
		int p;
		int n;
		p = 0;
		case (cmd)
			CMD_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					queue_reply(STAT_FULL, val, 0, 1'b1);
				end else begin
					while (p < shadow_len && shadow_list[p] < val)
						p++;
					for (int i = shadow_len; i > p; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[p] = val;
					shadow_len++;
					queue_reply(STAT_OK, val, p, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (shadow_len == 0) begin
					queue_reply(STAT_EMPTY, val, 0, 1'b1);
				end else begin
					while (p < shadow_len && shadow_list[p] != val)
						p++;
					if (p >= shadow_len) begin
						queue_reply(STAT_NOT_FOUND, val, 0, 1'b1);
					end else begin
						for (int i = p; i + 1 < shadow_len; i++)
							shadow_list[i] = shadow_list[i+1];
						shadow_len--;
						queue_reply(STAT_OK, val, p, 1'b1);
					end
				end
			end
			CMD_DUMP: begin
				if (shadow_len == 0) begin
					queue_reply(STAT_EMPTY, '0, 0, 1'b1);
				end else begin
					n = (shadow_len > MAX_RESULTS) ? MAX_RESULTS : shadow_len;
					for (int i = 0; i < n; i++)
						queue_reply(STAT_OK, shadow_list[i], i, i + 1 == n);
				end
			end
			default: ;  // unused code: no transaction out, no change
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void add_item(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
		list_cmd_t it;
		it.cmd   = cmd;
		it.val   = val;
		it.gap   = (gen_quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 17);
		it.drain = drain_next;
		drain_next = 1'b0;
		cmd_queue.push_back(it);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3:    return $urandom;
			default: return $signed($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	function automatic void gen_insert();
		logic signed [VAL_W-1:0] v;
		v = pick_value();
		if (gen_pool.size() < CAPACITY)
			gen_pool.push_back(v);
		add_item(CMD_INSERT, v);
	endfunction

	function automatic void gen_delete(bit hit);
		logic signed [VAL_W-1:0] v;
		if (hit && gen_pool.size() > 0)
			v = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
		else
			v = pick_value();
		foreach (gen_pool[i]) begin
			if (gen_pool[i] == v) begin
				gen_pool.delete(i);
				break;
			end
		end
		add_item(CMD_DELETE, v);
	endfunction

	function automatic void gen_fill();
		while (gen_pool.size() < CAPACITY)
			gen_insert();
		gen_insert();
		gen_insert();
		add_item(CMD_DUMP, $urandom);
	endfunction

	function automatic void gen_drain();
		while (gen_pool.size() > 0)
			gen_delete(1'b1);
		gen_delete(1'b0);
		add_item(CMD_DUMP, $urandom);
	endfunction

	function automatic void gen_mix();
		int r;
		repeat (20) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				gen_insert();
			else if (r < 80)
				gen_delete($urandom_range(0, 3) != 0);
			else if (r < 94)
				add_item(CMD_DUMP, $urandom);
			else
				add_item(CMD_UNUSED, $urandom);
		end
	endfunction

	function automatic void build_stimulus();
		gen_quiet = 1'b0;
		drain_next = 1'b0;
		add_item(CMD_DUMP, '0);
		add_item(CMD_DELETE, 32'sd5);
		add_item(CMD_UNUSED, 32'shffff_ffff);
		add_item(CMD_INSERT, 32'sd0);
		add_item(CMD_INSERT, VAL_MAX);
		add_item(CMD_INSERT, VAL_MIN);
		add_item(CMD_INSERT, -32'sd1);
		add_item(CMD_INSERT, 32'sd0);    // duplicate goes ahead of the stored one
		add_item(CMD_INSERT, 32'sd1);
		add_item(CMD_DUMP, 32'shffff_ffff);
		add_item(CMD_DELETE, 32'sd7);
		add_item(CMD_DELETE, 32'sd0);
		add_item(CMD_DELETE, VAL_MIN);
		add_item(CMD_DELETE, VAL_MAX);
		add_item(CMD_DUMP, '0);
		add_item(CMD_UNUSED, '0);
		gen_pool = '{-32'sd1, 32'sd0, 32'sd1};

		gen_fill();
		drain_next = 1'b1;
		while (cmd_queue.size() < ITEM_TARGET) begin
			gen_quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0:       gen_fill();
				1:       gen_drain();
				default: gen_mix();
			endcase
			if ($urandom_range(0, 7) == 0)
				drain_next = 1'b1;
		end
		gen_quiet = 1'b0;
		drain_next = 1'b1;
		gen_fill();
		gen_drain();
	endfunction

	// ---------------------------------------------------------------- driver

	int gap_left;
	bit gap_armed;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_left = 0;
			gap_armed = 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				update_sorted_list(s_axis_tuser, s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_queue.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					if (!gap_armed) begin
						gap_left = cmd_queue[0].gap;
						gap_armed = 1'b1;
					end
					if (gap_left > 0) begin
						gap_left--;
						s_axis_tvalid <= 1'b0;
					end else if (cmd_queue[0].drain && list_replies.size() != 0) begin
						s_axis_tvalid <= 1'b0;
					end else begin
						s_axis_tvalid <= 1'b1;
						s_axis_tuser  <= cmd_queue[0].cmd;
						s_axis_tdata  <= cmd_queue[0].val;
						void'(cmd_queue.pop_front());
						gap_armed = 1'b0;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	int stall_left;
	int replies_seen;
	bit rx_quiet;

	function automatic void check_field(string name, longint exp, longint act);
		if (exp != act) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
			faults++;
		end
	endfunction

	function automatic void check_reply();
		list_reply_t r;
		if (list_replies.size() == 0) begin
			$display("%0t: unexpected transaction, expected none actual value %0d status %0d",
				$time, $signed(m_axis_tdata[31:0]), m_axis_tuser);
			faults++;
			return;
		end
		r = list_replies.pop_front();
		check_field("status", r.status, m_axis_tuser);
		check_field("entry_value", r.value, $signed(m_axis_tdata[31:0]));
		check_field("position", r.pos, m_axis_tdata[36:32]);
		check_field("entry_count", r.count, m_axis_tdata[42:37]);
		check_field("last", r.last, m_axis_tlast);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
			replies_seen = 0;
			rx_quiet = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_reply();
				replies_seen++;
				if (replies_seen % 32 == 0)
					rx_quiet = ($urandom_range(0, 3) == 0);
				stall_left = (rx_quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 17);
				if (replies_seen == HOLD_AT)
					stall_left = HOLD_CYCLES;  // long back-pressure, input side keeps offering
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	int cycles;

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_sorted_list_engine: errors");
		$finish;
	end

	initial begin
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (cmd_queue.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (list_replies.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (faults == 0 && list_replies.size() == 0)
			$display("tb_sorted_list_engine: clean");
		else
			$display("tb_sorted_list_engine: errors");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/sle_pkg.sv
design/sle_cell.sv
design/sorted_list_engine.sv
design/sle_checker.sv
bench/tb_sorted_list_engine.sv
